@@ rtl/core/mafe_pkg.sv @@
`default_nettype none

package mafe_pkg;

  // Frame characters.
  localparam logic [7:0] CH_START = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DIGIT = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h41;

  // Character positions within one item's run of characters.
  localparam logic [3:0] STEP_START  = 4'd0;
  localparam logic [3:0] STEP_ADDR_H = 4'd1;
  localparam logic [3:0] STEP_ADDR_L = 4'd2;
  localparam logic [3:0] STEP_DATA_H = 4'd3;
  localparam logic [3:0] STEP_DATA_L = 4'd4;
  localparam logic [3:0] STEP_LRC_H  = 4'd5;
  localparam logic [3:0] STEP_LRC_L  = 4'd6;
  localparam logic [3:0] STEP_CR     = 4'd7;
  localparam logic [3:0] STEP_LF     = 4'd8;

  // One input beat.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       opens_frame;
    logic       closes_frame;
  } item_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] ascii_char;
    logic       end_of_run;
    logic       end_of_frame;
  } char_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic       opens_frame;
    logic       closes_frame;
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] lrc;
  } job_t;

  // Uppercase hex character of one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_DIGIT + {4'd0, nib};
    end else begin
      c = CH_ALPHA + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mafe_front.sv @@
`default_nettype none

module mafe_front
  import mafe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_data,
  input  wire logic       item_valid,
  input  wire item_t      item,
  input  wire logic       full,
  output logic            push,
  output job_t            job
);

  logic [7:0] device_address;
  logic [7:0] lrc_sum;
  logic [7:0] sum_next;

  // The address register is written by the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
    end else if (cfg_valid) begin
      device_address <= cfg_data;
    end
  end

  // A beat is taken whenever the queue has room.
  assign push = item_valid && !full;

  // Running sum restarts on an opening item and includes this byte.
  assign sum_next = item.opens_frame ? (device_address + item.byte_value)
                                     : (lrc_sum + item.byte_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      lrc_sum <= 8'd0;
    end else if (push) begin
      lrc_sum <= item.closes_frame ? 8'd0 : sum_next;
    end
  end

  // Build the job descriptor for the back end.
  always_comb begin
    job.opens_frame  = item.opens_frame;
    job.closes_frame = item.closes_frame;
    job.addr         = device_address;
    job.data         = item.byte_value;
    job.lrc          = 8'd0 - sum_next;
  end

endmodule

`default_nettype wire

@@ rtl/core/mafe_queue.sv @@
`default_nettype none

module mafe_queue
  import mafe_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output job_t      rd_job,
  output logic      full,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full   = (count == FULL_COUNT);
  assign empty  = (count == '0);
  assign rd_job = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mafe_back.sv @@
`default_nettype none

module mafe_back
  import mafe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic empty,
  output logic      pop,
  output logic      frame_valid,
  input  wire logic frame_stall,
  output char_t     frame_char
);

  logic       busy;
  logic [3:0] step;
  logic [3:0] step_cur;
  logic [3:0] step_end;
  logic       load;
  logic       last;
  char_t      beat;

  // Output register takes a new beat when empty or being drained.
  assign load = !empty && (!frame_valid || !frame_stall);

  // Where this job's run begins and ends.
  assign step_cur = busy ? step : (job.opens_frame ? STEP_START : STEP_DATA_H);
  assign step_end = job.closes_frame ? STEP_LF : STEP_DATA_L;
  assign last     = (step_cur == step_end);
  assign pop      = load && last;

  // Select the character for the current position.
  always_comb begin
    case (step_cur)
      STEP_START:  beat.ascii_char = CH_START;
      STEP_ADDR_H: beat.ascii_char = hex_char(job.addr[7:4]);
      STEP_ADDR_L: beat.ascii_char = hex_char(job.addr[3:0]);
      STEP_DATA_H: beat.ascii_char = hex_char(job.data[7:4]);
      STEP_DATA_L: beat.ascii_char = hex_char(job.data[3:0]);
      STEP_LRC_H:  beat.ascii_char = hex_char(job.lrc[7:4]);
      STEP_LRC_L:  beat.ascii_char = hex_char(job.lrc[3:0]);
      STEP_CR:     beat.ascii_char = CH_CR;
      STEP_LF:     beat.ascii_char = CH_LF;
      default:     beat.ascii_char = CH_LF;
    endcase
    beat.end_of_run   = last;
    beat.end_of_frame = (step_cur == STEP_LF);
  end

  // Position sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_START;
    end else if (load) begin
      busy <= !last;
      step <= step_cur + 4'd1;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (load) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      frame_char <= beat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/modbus_ascii_frame_encoder.sv @@
// Modbus ASCII request frame encoder with LRC.
// A taken beat is stored in the queue, then its characters in the output register.
// One character per cycle while frame_stall is low, set by the single output
// register; an item is 2 to 9 characters (5 if opening, +4 if closing).
// Reset (rst, synchronous): queue emptied, LRC sum cleared, device address set to 1.
`default_nettype none

module modbus_ascii_frame_encoder
  import mafe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire item_t      item,
  output logic            frame_valid,
  input  wire logic       frame_stall,
  output char_t           frame_char
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t wr_job;
  job_t rd_job;

  // The address register can always be written.
  assign cfg_ready  = 1'b1;
  assign item_stall = full;

  // Front end: takes items, keeps the LRC and the address.
  mafe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .full       (full),
    .push       (push),
    .job        (wr_job)
  );

  // Short queue between the two halves.
  mafe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (empty)
  );

  // Back end: serializes each job into characters.
  mafe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (rd_job),
    .empty       (empty),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_char  (frame_char)
  );

endmodule

`default_nettype wire
